// File: hdl/wpm_pkg.sv
package wpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LANES       = 8;
    localparam int NUM_CHUNKS  = MAX_PATTERN / LANES;
    localparam int SYM_W       = 8;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = IDX_W + 1;
    localparam int LANE_W      = $clog2(LANES);
    localparam int CHUNK_W     = IDX_W - LANE_W;
    localparam int WORD_W      = LANES * SYM_W;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'd63;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
        logic restart;
        logic text_start;
        logic fetch;
        logic calc;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic last_chunk;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/wpm_datapath.sv
module wpm_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wpm_pkg::t_dp_cmd      i_cmd,
    input  logic [7:0]            i_symbol,
    input  logic                  i_m_tready,
    output wpm_pkg::t_dp_status   o_status,
    output logic                  o_m_valid,
    output logic                  o_matched,
    output logic                  o_overflow
);
    import wpm_pkg::*;

    // pattern bytes, one word of LANES bytes per chunk
    logic [WORD_W-1:0]  r_mem [NUM_CHUNKS];
    logic [WORD_W-1:0]  r_rd_data;

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   len_m1;
    logic               r_ovf;
    logic [MAX_PATTERN-1:0] r_row;
    logic [MAX_PATTERN-1:0] r_empty_row;
    logic               r_all_star;
    logic               r_at_start;
    logic [SYM_W-1:0]   r_sym;
    logic [CHUNK_W-1:0] r_chunk;
    logic               r_left;
    logic               r_diag;
    logic               r_out_valid;
    logic               r_matched;
    logic               r_out_ovf;

    logic               room;
    logic               star_bit;
    logic [MAX_PATTERN-1:0] n_empty_row;
    logic [LANES-1:0]   n_cells;
    logic               n_left;
    logic               n_diag;
    logic [LANES-1:0]   up_bits;
    logic               whole;

    assign room     = (r_len < LEN_W'(MAX_PATTERN));
    assign star_bit = r_all_star && (i_symbol == SYM_STAR) && room;
    assign n_empty_row = r_empty_row | (MAX_PATTERN'(star_bit) << r_len[IDX_W-1:0]);
    assign len_m1   = r_len - LEN_W'(1);
    assign up_bits  = r_row[r_chunk*LANES +: LANES];

    always_comb begin
        logic             left;
        logic             diag;
        logic [SYM_W-1:0] p;
        left = r_left;
        diag = r_diag;
        n_cells = '0;
        for (int j = 0; j < LANES; j++) begin
            p = r_rd_data[j*SYM_W +: SYM_W];
            if (p == SYM_STAR) begin
                n_cells[j] = left | up_bits[j];
            end else if (p == SYM_ANY || p == r_sym) begin
                n_cells[j] = diag;
            end else begin
                n_cells[j] = 1'b0;
            end
            left = n_cells[j];
            diag = up_bits[j];
        end
        n_left = left;
        n_diag = diag;
    end

    assign whole = (r_len == '0) ? r_at_start : r_row[len_m1[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && room) begin
            r_mem[r_len[IDX_W-1:LANE_W]][r_len[LANE_W-1:0]*SYM_W +: SYM_W] <= i_symbol;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_mem[r_chunk];
        end
        if (i_cmd.text_start) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.emit) begin
            r_matched <= whole;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_row       <= '0;
            r_empty_row <= '0;
            r_all_star  <= 1'b1;
            r_at_start  <= 1'b1;
            r_chunk     <= '0;
            r_left      <= 1'b0;
            r_diag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_len       <= '0;
                r_ovf       <= 1'b0;
                r_row       <= '0;
                r_empty_row <= '0;
                r_all_star  <= 1'b1;
                r_at_start  <= 1'b1;
            end
            if (i_cmd.append) begin
                if (room) begin
                    r_len      <= r_len + LEN_W'(1);
                    r_all_star <= star_bit;
                end else begin
                    r_ovf <= 1'b1;
                end
                r_empty_row <= n_empty_row;
                r_row       <= n_empty_row;
                r_at_start  <= 1'b1;
            end
            if (i_cmd.restart) begin
                r_row      <= r_empty_row;
                r_at_start <= 1'b1;
            end
            if (i_cmd.text_start) begin
                r_chunk    <= '0;
                r_left     <= 1'b0;
                r_diag     <= r_at_start;
                r_at_start <= 1'b0;
            end
            if (i_cmd.calc) begin
                r_row[r_chunk*LANES +: LANES] <= n_cells;
                r_left  <= n_left;
                r_diag  <= n_diag;
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.len_zero   = (r_len == '0);
    assign o_status.last_chunk = (r_chunk == len_m1[IDX_W-1:LANE_W]);
    assign o_status.out_free   = !r_out_valid || i_m_tready;
    assign o_m_valid  = r_out_valid;
    assign o_matched  = r_matched;
    assign o_overflow = r_out_ovf;

endmodule

// File: hdl/wpm_ctrl.sv
module wpm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  wpm_pkg::t_mode        i_mode,
    input  wpm_pkg::t_dp_status   i_status,
    output logic                  o_s_ready,
    output wpm_pkg::t_dp_cmd      o_cmd
);
    import wpm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_s_ready = (r_state == ST_IDLE);
    assign take      = o_s_ready && i_s_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    unique case (i_mode)
                        MODE_CLEAR:   o_cmd.clear = 1'b1;
                        MODE_APPEND:  o_cmd.append = 1'b1;
                        MODE_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_state = ST_EMIT;
                        end
                        MODE_TEXT: begin
                            o_cmd.text_start = 1'b1;
                            n_state = i_status.len_zero ? ST_EMIT : ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = i_status.last_chunk ? ST_EMIT : ST_FETCH;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/wildcard_pattern_matcher.sv
// Glob matcher: '?' matches any one byte, '*' any run of bytes (also empty).
// Slave channel: one beat per item. tuser[1:0] is the mode (clear pattern,
// append pattern byte, text byte, restart text); tdata[7:0] is the symbol.
// Master channel: one beat for each text byte and each restart, carrying
// tdata[0] = whole pattern matches the text so far, tdata[1] = sticky
// overflow (a pattern byte beyond 64 was dropped). Clear and append give
// no beat. A restart goes through the emit state; its result beat is
// registered from there, and the emit state waits while the output
// register is full. A text byte walks the stored pattern eight positions
// at a time through one fetch/compute pair on the pattern memory, then
// passes through the emit state likewise to give its result beat.
// The slave side takes one item at a time; a new item is accepted while the
// previous result still waits in the output register, and a stalled receiver
// holds the next result in its final state until the register frees.
// Reset (i_rst_n low, synchronous) empties the pattern, clears overflow and
// rewinds the text; no pass over the pattern memory is needed.
module wildcard_pattern_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic [1:0] i_s_axis_tuser,   // [1:0] mode
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import wpm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       matched;
    logic       overflow;

    wpm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_mode    (t_mode'(i_s_axis_tuser)),
        .i_status  (status),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    wpm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_symbol   (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_status   (status),
        .o_m_valid  (o_m_axis_tvalid),
        .o_matched  (matched),
        .o_overflow (overflow)
    );

    assign o_m_axis_tdata = {6'b0, overflow, matched};

endmodule
